### rtl/core/assert_macros.svh
// Assertion helpers shared by the ring FIFO RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define BRF_ASSERT_ALWAYS(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define BRF_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define BRF_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define BRF_ASSERT_ALWAYS(name, clk, rst, expr, msg)

`define BRF_ASSERT_IMPLY(name, clk, rst, ante, cons, msg)

`define BRF_ASSERT_NEXT(name, clk, rst, ante, cons, msg)

`endif

`endif

### rtl/core/brf_pkg.sv
package brf_pkg;

   localparam int OP_W = 3;
   localparam int BYTE_W = 8;
   localparam int PTR_W = 8;
   localparam int LEN_W = 9;
   localparam int MAX_LEN = 256;
   localparam int MIN_LEN = 2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = 1;
   localparam int QCNT_W = 2;

   localparam int DIV_STEPS = 8;
   localparam int STEP_W = 3;

   localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
   localparam logic [OP_W-1:0] OP_OVERWRITE = 3'd1;
   localparam logic [OP_W-1:0] OP_READ = 3'd2;
   localparam logic [OP_W-1:0] OP_PEEK = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

   typedef enum logic [2:0] {
      CMD_PUSH,
      CMD_FORCE,
      CMD_POP,
      CMD_PEEK,
      CMD_CLEAR,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [BYTE_W-1:0] data;
      logic [BYTE_W-1:0] offset;
   } cmd_type;

endpackage

### rtl/core/brf_req_if.sv
interface brf_req_if import brf_pkg::*; ();
   logic valid;
   logic ready;
   logic [OP_W-1:0] operation;
   logic [BYTE_W-1:0] data_byte;
   logic [BYTE_W-1:0] peek_offset;

   modport source (output valid, operation, data_byte, peek_offset, input ready);
   modport sink (input valid, operation, data_byte, peek_offset, output ready);
endinterface

### rtl/core/brf_rsp_if.sv
interface brf_rsp_if import brf_pkg::*; ();
   logic valid;
   logic ready;
   logic [BYTE_W-1:0] read_data;
   logic done_res;
   logic [BYTE_W-1:0] fill_count;
   logic [BYTE_W-1:0] free_count;
   logic [BYTE_W-1:0] bytes_after_offset;

   modport source (output valid, read_data, done_res, fill_count, free_count,
      bytes_after_offset, input ready);
   modport sink (input valid, read_data, done_res, fill_count, free_count,
      bytes_after_offset, output ready);
endinterface

### rtl/core/brf_csr_if.sv
interface brf_csr_if import brf_pkg::*; ();
   logic valid;
   logic ready;
   logic [LEN_W-1:0] buffer_length;

   modport source (output valid, buffer_length, input ready);
   modport sink (input valid, buffer_length, output ready);
endinterface

### rtl/core/brf_queue.sv
module brf_queue import brf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   cmd_type entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd = entries_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
         2'b10: begin
            count_in = count_ff + QCNT_W'(1);
         end
         2'b01: begin
            count_in = count_ff - QCNT_W'(1);
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### rtl/core/brf_front.sv
`include "assert_macros.svh"

module brf_front import brf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   brf_req_if.sink          req,
   input  logic [LEN_W-1:0] len_eff,
   output logic             push_valid,
   input  logic             push_ready,
   output cmd_type          push_cmd
);

   typedef enum logic [1:0] {
      F_EMPTY,
      F_DIVIDE,
      F_FULL
   } front_state_type;

   front_state_type state_ff, state_in;
   cmd_kind_type kind_ff, kind_in, kind_new;
   logic [BYTE_W-1:0] data_ff, data_in;
   logic [BYTE_W-1:0] dividend_ff, dividend_in;
   logic [LEN_W-1:0] rem_ff, rem_in, rem_next;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [LEN_W:0] trial;
   logic [LEN_W:0] len_ext;
   logic accept;

   assign req.ready = (state_ff == F_EMPTY) || ((state_ff == F_FULL) && push_ready);
   assign accept = req.valid && req.ready;
   assign push_valid = (state_ff == F_FULL);
   assign push_cmd = '{kind: kind_ff, data: data_ff, offset: rem_ff[BYTE_W-1:0]};

   always_comb begin
      unique case (req.operation)
         OP_WRITE: begin
            kind_new = CMD_PUSH;
         end
         OP_OVERWRITE: begin
            kind_new = CMD_FORCE;
         end
         OP_READ: begin
            kind_new = CMD_POP;
         end
         OP_PEEK: begin
            kind_new = CMD_PEEK;
         end
         OP_CLEAR: begin
            kind_new = CMD_CLEAR;
         end
         default: begin
            kind_new = CMD_NOP;
         end
      endcase
   end

   // One restoring remainder step per cycle, most significant offset bit first.
   always_comb begin
      trial = {rem_ff, dividend_ff[BYTE_W-1]};
      len_ext = {1'b0, len_eff};
      if (trial >= len_ext) begin
         rem_next = LEN_W'(trial - len_ext);
      end else begin
         rem_next = trial[LEN_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      kind_in = kind_ff;
      data_in = data_ff;
      dividend_in = dividend_ff;
      rem_in = rem_ff;
      step_in = step_ff;
      unique case (state_ff)
         F_EMPTY, F_FULL: begin
            if (accept) begin
               kind_in = kind_new;
               data_in = req.data_byte;
               dividend_in = req.peek_offset;
               rem_in = '0;
               step_in = '0;
               state_in = (kind_new == CMD_PEEK) ? F_DIVIDE : F_FULL;
            end else if (state_ff == F_FULL && push_ready) begin
               state_in = F_EMPTY;
            end
         end
         F_DIVIDE: begin
            rem_in = rem_next;
            dividend_in = {dividend_ff[BYTE_W-2:0], 1'b0};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = F_FULL;
            end
         end
         default: begin
            state_in = F_EMPTY;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_EMPTY;
      end else begin
         state_ff <= state_in;
      end
      kind_ff <= kind_in;
      data_ff <= data_in;
      dividend_ff <= dividend_in;
      rem_ff <= rem_in;
      step_ff <= step_in;
   end

   `BRF_ASSERT_IMPLY(a_rem_below_len, clock, reset, state_ff == F_DIVIDE, rem_ff < len_eff, "remainder reached the buffer length")

endmodule

### rtl/core/brf_back.sv
`include "assert_macros.svh"

module brf_back import brf_pkg::*; #(
   parameter int DEPTH = 256
) (
   input  logic             clock,
   input  logic             reset,
   brf_csr_if.sink          csr,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  cmd_type          cmd,
   brf_rsp_if.source        rsp,
   output logic [LEN_W-1:0] len_eff
);

   localparam int MEM_DEPTH = (DEPTH < MAX_LEN) ? DEPTH : MAX_LEN;
   localparam int ADDR_W = $clog2(MEM_DEPTH);
   localparam logic [LEN_W-1:0] LEN_TOP = LEN_W'(MEM_DEPTH);
   localparam logic [LEN_W-1:0] LEN_BOTTOM = LEN_W'(MIN_LEN);

   logic [BYTE_W-1:0] mem [MEM_DEPTH];
   logic [BYTE_W-1:0] mem_q_ff;

   logic [LEN_W-1:0] len_ff, len_in;
   logic [PTR_W-1:0] rp_ff, rp_in, wp_ff, wp_in;
   logic [PTR_W-1:0] rp_bump, wp_bump;
   logic rsp_valid_ff;
   logic use_mem_ff, use_mem_in;
   logic done_ff, done_in;
   logic [BYTE_W-1:0] fill_ff, free_ff, after_ff;
   logic [LEN_W-1:0] fill_w, free_w, after_w;
   logic [LEN_W-1:0] rp_ext, wp_ext, rp_in_ext, wp_in_ext, off_ext;
   logic [ADDR_W-1:0] rd_addr;
   logic pop, full, wr_en, csr_write;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p,
                                             input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] nxt;
      nxt = {1'b0, p} + LEN_W'(1);
      return (nxt == len) ? '0 : nxt[PTR_W-1:0];
   endfunction

   assign csr.ready = 1'b1;
   assign csr_write = csr.valid && csr.ready;
   assign len_eff = len_ff;

   assign pop = cmd_valid && (!rsp_valid_ff || rsp.ready);
   assign cmd_ready = !rsp_valid_ff || rsp.ready;

   assign rp_bump = bump(rp_ff, len_ff);
   assign wp_bump = bump(wp_ff, len_ff);
   assign full = (wp_bump == rp_ff);
   assign rp_ext = {1'b0, rp_ff};
   assign wp_ext = {1'b0, wp_ff};
   assign off_ext = {1'b0, cmd.offset};
   assign rd_addr = (cmd.kind == CMD_PEEK) ? cmd.offset[ADDR_W-1:0] : rp_ff[ADDR_W-1:0];

   always_comb begin
      if (csr.buffer_length < LEN_BOTTOM) begin
         len_in = LEN_BOTTOM;
      end else if (csr.buffer_length > LEN_TOP) begin
         len_in = LEN_TOP;
      end else begin
         len_in = csr.buffer_length;
      end
   end

   always_comb begin
      rp_in = rp_ff;
      wp_in = wp_ff;
      done_in = 1'b0;
      use_mem_in = 1'b0;
      after_w = '0;
      wr_en = 1'b0;
      if (pop) begin
         unique case (cmd.kind)
            CMD_PUSH: begin
               if (!full) begin
                  wr_en = 1'b1;
                  wp_in = wp_bump;
                  done_in = 1'b1;
               end
            end
            CMD_FORCE: begin
               wr_en = 1'b1;
               wp_in = wp_bump;
               if (full) begin
                  rp_in = rp_bump;
               end
               done_in = 1'b1;
            end
            CMD_POP: begin
               if (rp_ff != wp_ff) begin
                  rp_in = rp_bump;
                  done_in = 1'b1;
                  use_mem_in = 1'b1;
               end
            end
            CMD_PEEK: begin
               if (off_ext <= wp_ext) begin
                  after_w = wp_ext - off_ext;
               end else begin
                  after_w = len_ff - off_ext + wp_ext;
               end
               if (after_w != '0) begin
                  done_in = 1'b1;
                  use_mem_in = 1'b1;
               end
            end
            CMD_CLEAR: begin
               rp_in = '0;
               wp_in = '0;
               done_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rp_in_ext = {1'b0, rp_in};
      wp_in_ext = {1'b0, wp_in};
      if (wp_in_ext >= rp_in_ext) begin
         fill_w = wp_in_ext - rp_in_ext;
      end else begin
         fill_w = len_ff - rp_in_ext + wp_in_ext;
      end
      free_w = len_ff - LEN_W'(1) - fill_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_TOP;
         rp_ff <= '0;
         wp_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            len_ff <= len_in;
            rp_ff <= '0;
            wp_ff <= '0;
         end else begin
            rp_ff <= rp_in;
            wp_ff <= wp_in;
         end
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         done_ff <= done_in;
         use_mem_ff <= use_mem_in;
         fill_ff <= fill_w[BYTE_W-1:0];
         free_ff <= free_w[BYTE_W-1:0];
         after_ff <= after_w[BYTE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wp_ff[ADDR_W-1:0]] <= cmd.data;
      end
      if (pop) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.read_data = use_mem_ff ? mem_q_ff : '0;
   assign rsp.done_res = done_ff;
   assign rsp.fill_count = fill_ff;
   assign rsp.free_count = free_ff;
   assign rsp.bytes_after_offset = after_ff;

   `BRF_ASSERT_ALWAYS(a_rp_in_range, clock, reset, rp_ext < len_ff, "read pointer beyond buffer length")
   `BRF_ASSERT_ALWAYS(a_wp_in_range, clock, reset, wp_ext < len_ff, "write pointer beyond buffer length")
   `BRF_ASSERT_NEXT(a_clear_zeroes, clock, reset, pop && cmd.kind == CMD_CLEAR, rp_ff == '0 && wp_ff == '0, "clear left a pointer set")

endmodule

### rtl/core/byte_ring_fifo_top.sv
// Byte ring FIFO with a configurable length of 2 up to min(DEPTH, 256) slots, one slot kept
// empty. Each request word carries one operation (bounded write, overwriting write, read,
// peek, clear) and yields exactly one response word with the fill and free counts after the
// operation. Writes, reads, clears and unknown codes are taken at one word per cycle while
// the queue has room; a peek blocks new requests while the eight-step remainder unit
// reduces the offset modulo the length one bit per cycle. A two-word queue separates the
// front end from the back end, which updates the pointers, accesses the storage array and
// registers the response, so a stalled response does not block new requests until the queue
// fills. Responses appear the cycle after the back end takes the word. Writing the length
// register empties the FIFO and is allowed only while no request is in flight; storage
// is not cleared, and peeking a slot that was never written returns an undefined byte.
module byte_ring_fifo_top import brf_pkg::*; #(
   parameter int DEPTH = 256
) (
   input  logic      clock,
   input  logic      reset,
   brf_req_if.sink   req_bus,
   brf_rsp_if.source rsp_bus,
   brf_csr_if.sink   csr_bus
);

   logic [LEN_W-1:0] len_eff;
   logic front_valid, front_ready;
   cmd_type front_cmd;
   logic back_valid, back_ready;
   cmd_type back_cmd;

   brf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .len_eff    (len_eff),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_cmd   (front_cmd)
   );

   brf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_cmd   (front_cmd),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_cmd    (back_cmd)
   );

   brf_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_bus),
      .cmd_valid (back_valid),
      .cmd_ready (back_ready),
      .cmd       (back_cmd),
      .rsp       (rsp_bus),
      .len_eff   (len_eff)
   );

endmodule
